// ===== src/sliding_window_max_core_defines.svh =====
// ---------------------------------------------------------------------------
// Sliding window max assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MAX_CORE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define SWM_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("swm: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swm: same-cycle implication violated");

// Consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swm: next-cycle implication violated");

`endif

// ===== src/swm_pkg.sv =====
// ---------------------------------------------------------------------------
// Sliding window max package
// Widths, register map, reset values and the structs shared by the cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int CFG_LEN_W      = 7;
  localparam int WINDOW_MAX_DEF = 64;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_LEN_W-1:0]       win_len_t;

  // Register word index, taken from paddr[2].
  localparam logic REG_WINDOW_LEN = 1'b0;

  localparam win_len_t WIN_LEN_RST = 7'd1;
  localparam sample_t  SAMPLE_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // What one cell hands to its neighbor: running max and whether it is live.
  typedef struct packed {
    logic    vld;
    sample_t val;
  } swm_link_t;

  // What every cell sees from the input side in the same cycle.
  typedef struct packed {
    logic    shift;
    logic    first;
    sample_t sample;
  } swm_bcast_t;

endpackage

// ===== src/swm_cell.sv =====
// ---------------------------------------------------------------------------
// Sliding window max cell
// Holds the maximum of the newest i+1 samples for its place i in the row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  swm_pkg::swm_bcast_t bcast_i,
  input  swm_pkg::swm_link_t  prev_i,
  output swm_pkg::swm_link_t  link_o,
  output swm_pkg::swm_link_t  nxt_o
);
  import swm_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  sample_t max_r;
  sample_t max_nxt;
  logic    keep_prev;

  // New max covers the new sample plus the left neighbor's span, aged by one.
  always_comb begin
    keep_prev = prev_i.vld && !bcast_i.first &&
                ($signed(prev_i.val) > $signed(bcast_i.sample));
    vld_nxt   = prev_i.vld && !bcast_i.first;
    max_nxt   = keep_prev ? prev_i.val : bcast_i.sample;
  end

  // Live flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (bcast_i.shift) begin
      vld_r <= vld_nxt;
    end
  end

  // The value itself is only read while the cell is live.
  always_ff @(posedge clk) begin
    if (bcast_i.shift) begin
      max_r <= max_nxt;
    end
  end

  assign link_o = '{vld: vld_r, val: max_r};
  assign nxt_o  = '{vld: vld_nxt, val: max_nxt};

endmodule

// ===== src/swm_obuf.sv =====
// ---------------------------------------------------------------------------
// Sliding window max output buffer
// Output register with a skid stage so the input stall is registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  swm_pkg::sample_t data_i,
  output logic             full_o,
  output logic             out_valid_o,
  output swm_pkg::sample_t out_data_o,
  input  logic             out_stall_i
);
  import swm_pkg::*;

  logic    out_vld_r;
  logic    out_vld_nxt;
  sample_t out_data_r;
  logic    skid_vld_r;
  logic    skid_vld_nxt;
  sample_t skid_data_r;
  logic    take;
  logic    load_out;
  logic    load_skid;
  logic    from_skid;

  assign take = out_vld_r && !out_stall_i;

  // The skid entry moves up first; a new item goes to whichever slot is free.
  always_comb begin
    from_skid    = skid_vld_r && (take || !out_vld_r);
    load_out     = from_skid || (!skid_vld_r && push_i && (take || !out_vld_r));
    load_skid    = !skid_vld_r && push_i && out_vld_r && !take;
    out_vld_nxt  = load_out || (out_vld_r && !take);
    skid_vld_nxt = load_skid || (skid_vld_r && !from_skid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= from_skid ? skid_data_r : data_i;
    end
    if (load_skid) begin
      skid_data_r <= data_i;
    end
  end

  assign full_o      = skid_vld_r;
  assign out_valid_o = out_vld_r;
  assign out_data_o  = out_data_r;

endmodule

// ===== src/sliding_window_max_core.sv =====
// With the output free, a result enters the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while in_stall is low; the row of max cells updates in a single step.
// in_stall rises only while the skid stage holds a result behind a stalled output.
// Reset clears all cell live flags and the live count, and sets window_len to 1.
// No clearing pass is run.
// ---------------------------------------------------------------------------
// Sliding window max core
// Running maximum over the last window_len samples, kept in a chain of cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_max_core #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  swm_pkg::sample_t                  in_sample,
  input  logic                              in_first,
  output logic                              out_valid,
  input  logic                              out_stall,
  output swm_pkg::sample_t                  out_window_max,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [swm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [swm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import swm_pkg::*;

  `include "sliding_window_max_core_defines.svh"

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  win_len_t          win_len_r;
  logic              cfg_wr;
  logic [IDX_W-1:0]  win_idx;
  logic [IDX_W-1:0]  live_idx_r;
  logic [IDX_W-1:0]  live_idx_nxt;
  logic              accept;
  logic              produce;
  logic              skid_full;
  swm_bcast_t        bcast;
  swm_bcast_t        head_bcast;
  swm_link_t         head_link;
  swm_link_t         link    [WINDOW_MAX];
  swm_link_t         nxt     [WINDOW_MAX];
  sample_t           tap_val;
  logic              win_full;
  logic [WINDOW_MAX-1:0] cell_vld;

  // Configuration port: one register, written on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WIN_LEN_RST;
    end else if (cfg_wr && (paddr[2] == REG_WINDOW_LEN)) begin
      win_len_r <= pwdata[CFG_LEN_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_WINDOW_LEN) begin
      prdata = APB_DATA_W'(win_len_r);
    end else begin
      prdata = '0;
    end
  end

  // Effective window length minus one, clamped to the row.
  always_comb begin
    if (win_len_r == '0) begin
      win_idx = '0;
    end else if (32'(win_len_r) > WINDOW_MAX) begin
      win_idx = IDX_W'(WINDOW_MAX - 1);
    end else begin
      win_idx = IDX_W'(win_len_r - CFG_LEN_W'(1));
    end
  end

  // Input handshake and the broadcast to every cell.
  assign in_stall = skid_full;
  assign accept   = in_valid && !in_stall;

  assign bcast      = '{shift: accept, first: in_first, sample: in_sample};
  assign head_bcast = '{shift: accept, first: 1'b0, sample: in_sample};
  assign head_link  = '{vld: 1'b1, val: SAMPLE_MIN};

  // Cell 0 always restarts from the new sample; the rest take their left neighbor.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      swm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .bcast_i (head_bcast),
        .prev_i  (head_link),
        .link_o  (link[i]),
        .nxt_o   (nxt[i])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .bcast_i (bcast),
        .prev_i  (link[i-1]),
        .link_o  (link[i]),
        .nxt_o   (nxt[i])
      );
    end
    assign cell_vld[i] = link[i].vld;
  end

  // Number of newest samples still eligible, minus one. A shorter window drops
  // older samples for good, so after the window grows again the span only
  // widens by one sample per item.
  always_comb begin
    if (in_first || !link[0].vld) begin
      live_idx_nxt = '0;
    end else if (live_idx_r < win_idx) begin
      live_idx_nxt = live_idx_r + IDX_W'(1);
    end else begin
      live_idx_nxt = win_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_idx_r <= '0;
    end else if (accept) begin
      live_idx_r <= live_idx_nxt;
    end
  end

  // A result is due once the cell at window length minus one is live; the value
  // comes from the cell that spans the eligible samples.
  assign win_full = nxt[win_idx].vld;
  assign tap_val  = nxt[live_idx_nxt].val;
  assign produce  = accept && win_full;

  swm_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (produce),
    .data_i      (tap_val),
    .full_o      (skid_full),
    .out_valid_o (out_valid),
    .out_data_o  (out_window_max),
    .out_stall_i (out_stall)
  );

  // Live cells always form a prefix of the row.
  `SWM_ASSERT_ALWAYS(a_vld_prefix, ((cell_vld + WINDOW_MAX'(1)) & cell_vld) == '0)
  // A held skid entry always sits behind a full output register.
  `SWM_ASSERT_SAME(a_skid_behind_out, skid_full, out_valid)
  // Every accepted item leaves the head cell live.
  `SWM_ASSERT_NEXT(a_head_live, accept, cell_vld[0])

endmodule
